FILE: rtl/core/rfhs_pkg.sv
// package for the rssi frequency hop scanner
// holds operation codes, register indexes, reset values and the channel tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rfhs_pkg;

  typedef logic [31:0] freq_t;
  typedef logic [3:0]  pos_t;
  typedef logic [1:0]  band_t;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  localparam logic [2:0] REG_BAND_SELECT    = 3'd0;
  localparam logic [2:0] REG_FIXED_MODE     = 3'd1;
  localparam logic [2:0] REG_FIXED_FREQ_HZ  = 3'd2;
  localparam logic [2:0] REG_RSSI_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_DWELL_TICKS    = 3'd4;

  localparam band_t BAND_ALL = 2'd0;
  localparam band_t BAND_433 = 2'd1;
  localparam band_t BAND_315 = 2'd2;

  localparam logic signed [7:0] RSSI_RESET      = -8'sd120;
  localparam logic signed [7:0] THRESHOLD_RESET = -8'sd70;
  localparam freq_t             FIXED_FREQ_RESET = 32'd433920000;
  localparam logic [15:0]       DWELL_RESET     = 16'd100;

  localparam pos_t COUNT_ALL = 4'd10;
  localparam pos_t COUNT_433 = 4'd5;
  localparam pos_t COUNT_315 = 4'd4;

  function automatic pos_t band_count(input band_t band);
    pos_t count;
    unique case (band)
      BAND_433: count = COUNT_433;
      BAND_315: count = COUNT_315;
      default:  count = COUNT_ALL;
    endcase
    return count;
  endfunction

  // entries past the table end read entry 0
  function automatic freq_t band_entry(input band_t band, input pos_t pos);
    freq_t f;
    pos_t  p;
    p = (pos >= band_count(band)) ? 4'd0 : pos;
    f = 32'd315000000;
    unique case (band)
      BAND_433: begin
        unique case (p)
          4'd1:    f = 32'd433420000;
          4'd2:    f = 32'd433920000;
          4'd3:    f = 32'd434420000;
          4'd4:    f = 32'd434775000;
          default: f = 32'd433075000;
        endcase
      end
      BAND_315: begin
        unique case (p)
          4'd1:    f = 32'd318000000;
          4'd2:    f = 32'd390000000;
          4'd3:    f = 32'd418000000;
          default: f = 32'd315000000;
        endcase
      end
      default: begin
        unique case (p)
          4'd1:    f = 32'd390000000;
          4'd2:    f = 32'd418000000;
          4'd3:    f = 32'd433075000;
          4'd4:    f = 32'd433920000;
          4'd5:    f = 32'd434420000;
          4'd6:    f = 32'd434775000;
          4'd7:    f = 32'd868350000;
          4'd8:    f = 32'd868950000;
          4'd9:    f = 32'd915000000;
          default: f = 32'd315000000;
        endcase
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rssi_frequency_hop_scanner.sv
// rssi frequency hop scanner top level
// input register, one pass of scan logic, result register
// depends on rfhs_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one start, tick or stop transfer per cycle unless the output side
// stalls, and returns one result per transfer, held in the input register
// and then the result register; the scan update (threshold compare, dwell
// subtract and compare, table step) sits between them. Configuration goes
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, not enforced by the block; tune_freq_hz is 0 when retune is 0.
module rssi_frequency_hop_scanner (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [2:0]                   cfg_index,
  input  wire  [31:0]                  cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [1:0]                   func,
  input  wire  [31:0]                  now_ticks,
  input  wire  signed [7:0]            rssi_sample,
  input  wire                          rssi_valid,
  input  wire                          capture_done,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         scan_tick,
  output logic                         signal_found,
  output logic                         retune,
  output rfhs_pkg::freq_t              tune_freq_hz,
  output rfhs_pkg::freq_t              capture_freq,
  output logic [3:0]                   channel_index,
  output logic signed [7:0]            last_rssi,
  output logic                         busy_capturing
);
  import rfhs_pkg::*;

  // configuration
  band_t             band_select;
  logic              fixed_mode;
  freq_t             fixed_freq;
  logic signed [7:0] rssi_thresh;
  logic [15:0]       dwell_ticks;

  // scan state
  pos_t              hop_position;
  logic [31:0]       dwell_start;
  logic signed [7:0] stored_rssi;
  logic              capture_active;
  freq_t             captured_freq;

  // input register
  logic              s1_valid;
  logic [1:0]        s1_func;
  logic [31:0]       s1_now;
  logic signed [7:0] s1_sample;
  logic              s1_rssi_valid;
  logic              s1_done;

  logic s1_advance;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_select <= BAND_ALL;
      fixed_mode  <= 1'b0;
      fixed_freq  <= FIXED_FREQ_RESET;
      rssi_thresh <= THRESHOLD_RESET;
      dwell_ticks <= DWELL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAND_SELECT:    band_select <= cfg_data[1:0];
        REG_FIXED_MODE:     fixed_mode  <= cfg_data[0];
        REG_FIXED_FREQ_HZ:  fixed_freq  <= cfg_data;
        REG_RSSI_THRESHOLD: rssi_thresh <= cfg_data[7:0];
        REG_DWELL_TICKS:    dwell_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func       <= func;
      s1_now        <= now_ticks;
      s1_sample     <= rssi_sample;
      s1_rssi_valid <= rssi_valid;
      s1_done       <= capture_done;
    end
  end

  // scan update
  pos_t              hop_position_next;
  logic [31:0]       dwell_start_next;
  logic signed [7:0] stored_rssi_next;
  logic              capture_active_next;
  freq_t             captured_freq_next;
  logic              tick_next;
  logic              found_next;
  logic              retune_next;
  freq_t             tune_next;

  logic signed [7:0] rssi_pick;
  logic [31:0]       elapsed;
  pos_t              pos_step;
  freq_t             cur_freq;

  always_comb begin
    rssi_pick = s1_rssi_valid ? s1_sample : stored_rssi;
    elapsed   = s1_now - dwell_start;
    pos_step  = (hop_position + 4'd1 >= band_count(band_select)) ? 4'd0
                                                                  : hop_position + 4'd1;
    cur_freq  = fixed_mode ? fixed_freq : band_entry(band_select, hop_position);

    hop_position_next   = hop_position;
    dwell_start_next    = dwell_start;
    stored_rssi_next    = stored_rssi;
    capture_active_next = capture_active;
    captured_freq_next  = captured_freq;
    tick_next           = 1'b0;
    found_next          = 1'b0;
    retune_next         = 1'b0;
    tune_next           = '0;

    unique case (s1_func)
      FUNC_START: begin
        hop_position_next  = '0;
        stored_rssi_next   = RSSI_RESET;
        captured_freq_next = fixed_mode ? fixed_freq : band_entry(band_select, 4'd0);
        dwell_start_next   = s1_now;
        retune_next        = 1'b1;
        tune_next          = captured_freq_next;
      end
      FUNC_TICK: begin
        tick_next = 1'b1;
        if (!capture_active && !s1_done) begin
          stored_rssi_next = rssi_pick;
          if (rssi_pick > rssi_thresh) begin
            captured_freq_next  = cur_freq;
            capture_active_next = 1'b1;
            found_next          = 1'b1;
          end else if (fixed_mode) begin
            dwell_start_next = s1_now;
          end else if (elapsed >= {16'd0, dwell_ticks}) begin
            hop_position_next = pos_step;
            retune_next       = 1'b1;
            tune_next         = band_entry(band_select, pos_step);
            dwell_start_next  = s1_now;
          end
        end
      end
      FUNC_STOP: begin
        capture_active_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_position   <= '0;
      dwell_start    <= '0;
      stored_rssi    <= RSSI_RESET;
      capture_active <= 1'b0;
      captured_freq  <= '0;
    end else if (s1_advance) begin
      hop_position   <= hop_position_next;
      dwell_start    <= dwell_start_next;
      stored_rssi    <= stored_rssi_next;
      capture_active <= capture_active_next;
      captured_freq  <= captured_freq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      scan_tick      <= tick_next;
      signal_found   <= found_next;
      retune         <= retune_next;
      tune_freq_hz   <= tune_next;
      capture_freq   <= captured_freq_next;
      channel_index  <= hop_position_next;
      last_rssi      <= stored_rssi_next;
      busy_capturing <= capture_active_next;
    end
  end

  // checks
  a_found_is_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && signal_found |-> scan_tick && busy_capturing && !retune)
    else $error("signal_found without tick or capture");

  a_no_tune_without_retune: assert property (@(posedge clk) disable iff (rst)
    out_valid && !retune |-> tune_freq_hz == '0)
    else $error("tune frequency set without retune");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    hop_position <= COUNT_ALL - 4'd1)
    else $error("hop position out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_now) && $stable(s1_func))
    else $error("input register lost a stalled transfer");

endmodule

`default_nettype wire
